### design/idp_pkg.sv
package idp_pkg;

  localparam logic [30:0] SAT31 = 31'h7FFF_FFFF;

  localparam logic [7:0] CHAR_P = 8'h50;
  localparam logic [7:0] CHAR_T = 8'h54;
  localparam logic [7:0] CHAR_Y = 8'h59;
  localparam logic [7:0] CHAR_M = 8'h4D;
  localparam logic [7:0] CHAR_D = 8'h44;
  localparam logic [7:0] CHAR_H = 8'h48;
  localparam logic [7:0] CHAR_S = 8'h53;
  localparam logic [7:0] CHAR_0 = 8'h30;
  localparam logic [7:0] CHAR_9 = 8'h39;

  localparam logic [2:0] FLD_YEAR  = 3'd0;
  localparam logic [2:0] FLD_MONTH = 3'd1;
  localparam logic [2:0] FLD_DAY   = 3'd2;
  localparam logic [2:0] FLD_HOUR  = 3'd3;
  localparam logic [2:0] FLD_MIN   = 3'd4;
  localparam logic [2:0] FLD_SEC   = 3'd5;

  localparam int UNIT_W = 25;

  typedef struct packed {
    logic        valid_res;
    logic [30:0] total;
    logic [30:0] prod;
    logic [7:0]  len;
  } fin_t;

  function automatic logic [UNIT_W-1:0] unit_seconds(input logic [2:0] fld);
    logic [UNIT_W-1:0] r;
    unique case (fld)
      FLD_YEAR:  r = UNIT_W'(365 * 86400);
      FLD_MONTH: r = UNIT_W'(30 * 86400);
      FLD_DAY:   r = UNIT_W'(86400);
      FLD_HOUR:  r = UNIT_W'(3600);
      FLD_MIN:   r = UNIT_W'(60);
      default:   r = UNIT_W'(1);
    endcase
    return r;
  endfunction

endpackage

### design/iso8601_duration_parser_unit.sv
// iso 8601 duration parser
// input channel: one character a cycle on in_char_code, with in_last on the
// final character of a text; an item is taken when in_valid is high and
// in_stall is low. the text is "P[nY][nM][nD][T[nH][nM][nS]]".
// result channel: one item per text, after its last character, carrying
// out_valid_res, out_seconds (saturated) and out_consumed_length; taken when
// out_valid is high and out_stall is low.
// result path: the last character passes the input register, the parse stage
// with the field multiply and the final sum stage into the output register.
// throughput: one character per cycle while in_stall is low; a field's scaled
// value is added into the total in the cycle after its unit letter.
// stall: while out_stall is high with the output register and the final
// stage both holding results, a waiting last character holds in_stall high;
// other characters keep flowing into the parse state.
// reset: synchronous active-low rst_n empties every stage and returns the
// parser to waiting for the leading P.
module iso8601_duration_parser_unit
  import idp_pkg::*;
#(
  parameter int MAX_LENGTH = 255
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char_code,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_valid_res,
  output logic [30:0] out_seconds,
  output logic [7:0]  out_consumed_length
);

  logic       in_vld_r;
  logic [7:0] char_r;
  logic       last_r;
  logic       take;
  logic       fin_free;
  logic       fin_load;
  fin_t       fin;

  assign take     = in_vld_r && (!last_r || fin_free);
  assign in_stall = in_vld_r && !take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_vld_r <= 1'b1;
    end else if (take) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      char_r <= in_char_code;
      last_r <= in_last;
    end
  end

  idp_parse #(
    .MAX_LENGTH(MAX_LENGTH)
  ) u_parse (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (take),
    .char_code(char_r),
    .last     (last_r),
    .fin_load (fin_load),
    .fin      (fin)
  );

  idp_sum u_sum (
    .clk                (clk),
    .rst_n              (rst_n),
    .fin_load           (fin_load),
    .fin                (fin),
    .fin_free           (fin_free),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_valid_res      (out_valid_res),
    .out_seconds        (out_seconds),
    .out_consumed_length(out_consumed_length)
  );

  a_stall_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (in_vld_r && last_r && !fin_free))
    else $error("input stalled without a blocked last item");

endmodule

### design/idp_parse.sv
module idp_parse
  import idp_pkg::*;
#(
  parameter int MAX_LENGTH = 255
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  logic [7:0] char_code,
  input  logic       last,
  output logic       fin_load,
  output fin_t       fin
);

  localparam int PW = $clog2(MAX_LENGTH + 1);
  localparam int CW = (PW > 8) ? PW : 8;

  localparam logic [1:0] PH_EXPECT_P = 2'd0;
  localparam logic [1:0] PH_DATE     = 2'd1;
  localparam logic [1:0] PH_TIME     = 2'd2;
  localparam logic [1:0] PH_STOP     = 2'd3;

  logic [1:0]    phase_r, phase_nxt;
  logic [2:0]    next_field_r, next_field_nxt;
  logic [30:0]   digit_r, digit_nxt;
  logic          has_digits_r, has_digits_nxt;
  logic [PW-1:0] position_r, position_nxt;
  logic [PW-1:0] committed_r, committed_nxt;
  logic [30:0]   total_r, total_nxt;
  logic [30:0]   prod_r, prod_nxt;
  logic          any_nz_r, any_nz_nxt;

  logic [31:0]   absorbed;
  logic [30:0]   sum_sat;
  logic [2:0]    fld;
  logic          fld_ok;
  logic [55:0]   prod_full;
  logic [30:0]   prod_sat;
  logic [34:0]   acc;
  logic [30:0]   acc_sat;
  logic          is_digit;
  logic [PW-1:0] end_pos;
  logic [CW-1:0] len_ext;

  // previous field product folds into the running total
  assign absorbed = 32'(total_r) + 32'(prod_r);
  assign sum_sat  = absorbed[31] ? SAT31 : absorbed[30:0];

  always_comb begin
    fld    = FLD_SEC;
    fld_ok = 1'b0;
    if (phase_r == PH_DATE) begin
      fld_ok = 1'b1;
      unique case (char_code)
        CHAR_Y:  fld = FLD_YEAR;
        CHAR_M:  fld = FLD_MONTH;
        CHAR_D:  fld = FLD_DAY;
        default: fld_ok = 1'b0;
      endcase
    end else if (phase_r == PH_TIME) begin
      fld_ok = 1'b1;
      unique case (char_code)
        CHAR_H:  fld = FLD_HOUR;
        CHAR_M:  fld = FLD_MIN;
        CHAR_S:  fld = FLD_SEC;
        default: fld_ok = 1'b0;
      endcase
    end
  end

  assign prod_full = 56'(digit_r) * 56'(unit_seconds(fld));
  assign prod_sat  = (prod_full > 56'(SAT31)) ? SAT31 : prod_full[30:0];

  // times ten by shift and add
  assign acc      = 35'({digit_r, 3'b000}) + 35'({digit_r, 1'b0}) + 35'(char_code[3:0]);
  assign acc_sat  = (acc > 35'(SAT31)) ? SAT31 : acc[30:0];
  assign is_digit = (char_code >= CHAR_0) && (char_code <= CHAR_9);
  assign end_pos  = position_r + PW'(1);

  always_comb begin
    phase_nxt      = phase_r;
    next_field_nxt = next_field_r;
    digit_nxt      = digit_r;
    has_digits_nxt = has_digits_r;
    position_nxt   = position_r;
    committed_nxt  = committed_r;
    total_nxt      = sum_sat;
    prod_nxt       = '0;
    any_nz_nxt     = any_nz_r;
    if (take) begin
      if (position_r >= PW'(MAX_LENGTH)) begin
        phase_nxt = PH_STOP;
      end else begin
        position_nxt = end_pos;
        unique case (phase_r)
          PH_STOP: begin
          end
          PH_EXPECT_P: begin
            if (char_code == CHAR_P) begin
              phase_nxt     = PH_DATE;
              committed_nxt = end_pos;
            end else begin
              phase_nxt = PH_STOP;
            end
          end
          PH_DATE, PH_TIME: begin
            priority if (is_digit) begin
              has_digits_nxt = 1'b1;
              digit_nxt      = acc_sat;
            end else if (has_digits_r) begin
              if (fld_ok && (fld >= next_field_r)) begin
                prod_nxt       = prod_sat;
                any_nz_nxt     = any_nz_r || (digit_r != '0);
                next_field_nxt = fld + 3'd1;
                digit_nxt      = '0;
                has_digits_nxt = 1'b0;
                committed_nxt  = end_pos;
              end else begin
                phase_nxt = PH_STOP;
              end
            end else if ((phase_r == PH_DATE) && (char_code == CHAR_T)) begin
              phase_nxt      = PH_TIME;
              next_field_nxt = FLD_HOUR;
              committed_nxt  = end_pos;
            end else begin
              phase_nxt = PH_STOP;
            end
          end
        endcase
      end
    end
  end

  assign len_ext = CW'(committed_nxt);

  always_comb begin
    fin.valid_res = any_nz_nxt;
    fin.total     = sum_sat;
    fin.prod      = prod_nxt;
    fin.len       = (len_ext > CW'(255)) ? 8'hFF : len_ext[7:0];
  end

  assign fin_load = take && last;

  always_ff @(posedge clk) begin
    if (!rst_n || fin_load) begin
      phase_r      <= PH_EXPECT_P;
      next_field_r <= FLD_YEAR;
      digit_r      <= '0;
      has_digits_r <= 1'b0;
      position_r   <= '0;
      committed_r  <= '0;
      total_r      <= '0;
      prod_r       <= '0;
      any_nz_r     <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      next_field_r <= next_field_nxt;
      digit_r      <= digit_nxt;
      has_digits_r <= has_digits_nxt;
      position_r   <= position_nxt;
      committed_r  <= committed_nxt;
      total_r      <= total_nxt;
      prod_r       <= prod_nxt;
      any_nz_r     <= any_nz_nxt;
    end
  end

  a_prod_clears_digits: assert property (@(posedge clk) disable iff (!rst_n)
    (prod_r != '0) |-> !has_digits_r)
    else $error("pending product while a number is open");

  a_expect_p_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_EXPECT_P) |-> (position_r == '0 && committed_r == '0 && !any_nz_r))
    else $error("state not clean while waiting for leading P");

  a_committed_bound: assert property (@(posedge clk) disable iff (!rst_n)
    committed_r <= position_r)
    else $error("committed length beyond position");

endmodule

### design/idp_sum.sv
module idp_sum
  import idp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fin_load,
  input  fin_t        fin,
  output logic        fin_free,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_valid_res,
  output logic [30:0] out_seconds,
  output logic [7:0]  out_consumed_length
);

  logic        fin_vld_r;
  fin_t        fin_r;
  logic        out_vld_r;
  logic        res_r;
  logic [30:0] sec_r;
  logic [7:0]  len_r;
  logic        out_adv;
  logic [31:0] total_sum;
  logic [30:0] total_sat;

  assign out_adv  = !out_vld_r || !out_stall;
  assign fin_free = !fin_vld_r || out_adv;

  assign total_sum = 32'(fin_r.total) + 32'(fin_r.prod);
  assign total_sat = total_sum[31] ? SAT31 : total_sum[30:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (fin_load) begin
        fin_vld_r <= 1'b1;
      end else if (out_adv) begin
        fin_vld_r <= 1'b0;
      end
      if (out_adv) begin
        out_vld_r <= fin_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      fin_r <= fin;
    end
    if (out_adv && fin_vld_r) begin
      res_r <= fin_r.valid_res;
      sec_r <= fin_r.valid_res ? total_sat : '0;
      len_r <= fin_r.valid_res ? fin_r.len : '0;
    end
  end

  assign out_valid           = out_vld_r;
  assign out_valid_res       = res_r;
  assign out_seconds         = sec_r;
  assign out_consumed_length = len_r;

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !res_r) |-> (sec_r == '0 && len_r == '0))
    else $error("invalid result with nonzero fields");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    fin_load |-> fin_free)
    else $error("final stage loaded while full");

endmodule
